[hw/rtl/cld_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the content-length deframer.
// No dependencies; used by the result channel interface, the top level and the bench.
package cld_pkg;

    localparam int unsigned PREFIX_LEN = 15;
    localparam int unsigned PREFIX_W   = 4;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;

    typedef enum logic [1:0] {
        KIND_BODY    = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_DISCARD = 2'd2
    } kind_t;

    typedef enum logic {
        PH_HEADER = 1'b0,
        PH_BODY   = 1'b1
    } phase_t;

    typedef enum logic [1:0] {
        TM_NONE    = 2'd0,
        TM_CR      = 2'd1,
        TM_CRLF    = 2'd2,
        TM_CRLFCR  = 2'd3
    } term_t;

    typedef enum logic [2:0] {
        NS_IDLE   = 3'd0,
        NS_LEAD   = 3'd1,
        NS_SIGN   = 3'd2,
        NS_DIGITS = 3'd3,
        NS_ENDED  = 3'd4
    } stage_t;

    // lower-case text of the length key, one character per position
    function automatic logic [7:0] key_char(input logic [PREFIX_W-1:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h63; // c
            4'd1:    c = 8'h6F; // o
            4'd2:    c = 8'h6E; // n
            4'd3:    c = 8'h74; // t
            4'd4:    c = 8'h65; // e
            4'd5:    c = 8'h6E; // n
            4'd6:    c = 8'h74; // t
            4'd7:    c = 8'h2D; // -
            4'd8:    c = 8'h6C; // l
            4'd9:    c = 8'h65; // e
            4'd10:   c = 8'h6E; // n
            4'd11:   c = 8'h67; // g
            4'd12:   c = 8'h74; // t
            4'd13:   c = 8'h68; // h
            4'd14:   c = 8'h3A; // :
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

[hw/rtl/cld_in_if.sv]
`timescale 1ns / 1ps
// Input byte channel: valid/ready handshake carrying one stream byte.
// No dependencies.
interface cld_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

[hw/rtl/cld_out_if.sv]
`timescale 1ns / 1ps
// Result channel: valid/ready handshake carrying kind, body byte and last mark.
// Depends on cld_pkg for the kind type.
interface cld_out_if;
    logic          valid;
    logic          ready;
    cld_pkg::kind_t kind;
    logic [7:0]    body_byte;
    logic          last_of_message;

    modport source (output valid, output kind, output body_byte, output last_of_message,
                    input ready);
    modport sink   (input valid, input kind, input body_byte, input last_of_message,
                    output ready);
endinterface

[hw/rtl/content_length_deframer.sv]
`timescale 1ns / 1ps
// Content-length deframer: splits a byte stream into headers and message bodies.
// Depends on cld_pkg, cld_in_if and cld_out_if.
//
//   channel   | direction | payload                              | handshake
//   in_ch     | in        | in_byte[7:0]                         | valid/ready
//   out_ch    | out       | kind[1:0], body_byte, last_of_message | valid/ready
//   cfg       | in        | cfg_data[31:0] (max_body_length)     | cfg_we only
//
// One byte per cycle while the output is not stalled. Each byte is decoded
// when accepted; its request lands in the output register, seen next cycle.
// in_ch.ready is high while the output register is empty or being taken, so a
// stalled output holds only the one pending request and stops input.
// Reset clears all parse state and loads the length limit with 1048576.
module content_length_deframer #(
    parameter int unsigned LENGTH_WIDTH = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    cld_in_if.sink       in_ch,
    cld_out_if.source    out_ch,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_data
);
    import cld_pkg::*;

    localparam int unsigned LW    = LENGTH_WIDTH;
    localparam int unsigned EXT_W = LENGTH_WIDTH + 4;
    localparam int unsigned CMP_W = (LENGTH_WIDTH > 32) ? LENGTH_WIDTH : 32;

    phase_t                 phase_reg,    phase_next;
    term_t                  term_reg,     term_next;
    logic [PREFIX_W-1:0]    prefix_reg,   prefix_next;
    logic                   mismatch_reg, mismatch_next;
    stage_t                 stage_reg,    stage_next;
    logic [LW-1:0]          acc_reg,      acc_next;
    logic                   found_reg,    found_next;
    logic                   bad_reg,      bad_next;
    logic [LW-1:0]          remain_reg,   remain_next;
    logic                   lovf_reg,     lovf_next;
    logic                   covf_reg,     covf_next;
    logic [31:0]            max_len_reg;

    logic                   out_valid_reg;
    kind_t                  out_kind_reg;
    logic [7:0]             out_byte_reg;
    logic                   out_last_reg;

    logic                   in_ready;
    logic                   in_fire;
    logic [7:0]             b;
    logic [7:0]             low_b;
    logic                   is_digit;
    logic                   is_space;
    logic [EXT_W-1:0]       acc_ext;
    logic [EXT_W-1:0]       acc_mul;
    logic                   mul_ovf;
    logic                   too_big;

    logic                   res_valid;
    kind_t                  res_kind;
    logic [7:0]             res_byte;
    logic                   res_last;

    assign in_ready    = !out_valid_reg || out_ch.ready;
    assign in_fire     = in_ch.valid && in_ready;
    assign in_ch.ready = in_ready;

    assign b        = in_ch.in_byte;
    assign low_b    = (b >= CH_UP_A && b <= CH_UP_Z) ? (b | 8'h20) : b;
    assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    assign is_space = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));

    // accumulator times ten plus digit, four spare bits to see overflow
    assign acc_ext = EXT_W'(acc_reg);
    assign acc_mul = (acc_ext << 3) + (acc_ext << 1) + EXT_W'(b[3:0]);
    assign mul_ovf = lovf_reg || (|acc_mul[EXT_W-1:LW]);

    assign too_big = covf_reg || (CMP_W'(remain_reg) > CMP_W'(max_len_reg));

    always_comb
    begin
        logic prev_cr;
        logic done;

        phase_next    = phase_reg;
        term_next     = term_reg;
        prefix_next   = prefix_reg;
        mismatch_next = mismatch_reg;
        stage_next    = stage_reg;
        acc_next      = acc_reg;
        found_next    = found_reg;
        bad_next      = bad_reg;
        remain_next   = remain_reg;
        lovf_next     = lovf_reg;
        covf_next     = covf_reg;
        res_valid     = 1'b0;
        res_kind      = KIND_BODY;
        res_byte      = 8'h00;
        res_last      = 1'b0;
        prev_cr       = (term_reg == TM_CR) || (term_reg == TM_CRLFCR);
        done          = 1'b0;

        if (in_fire)
        begin
            if (phase_reg == PH_BODY)
            begin
                res_valid = 1'b1;
                res_byte  = b;
                res_last  = (remain_reg == LW'(1));
                if (remain_reg != '0)
                begin
                    remain_next = remain_reg - LW'(1);
                end
                if (remain_reg <= LW'(1))
                begin
                    phase_next = PH_HEADER;
                end
            end
            else
            begin
                if (b == CH_CR)
                begin
                    term_next = (term_reg == TM_CRLF) ? TM_CRLFCR : TM_CR;
                end
                else if (b == CH_LF)
                begin
                    done      = (term_reg == TM_CRLFCR);
                    term_next = (term_reg == TM_CR) ? TM_CRLF : TM_NONE;
                end
                else
                begin
                    term_next = TM_NONE;
                end

                if (done)
                begin
                    // end of header: clear line and header state
                    term_next     = TM_NONE;
                    prefix_next   = '0;
                    mismatch_next = 1'b0;
                    stage_next    = NS_IDLE;
                    acc_next      = '0;
                    lovf_next     = 1'b0;
                    found_next    = 1'b0;
                    bad_next      = 1'b0;
                    covf_next     = 1'b0;
                    if (bad_reg || !found_reg || too_big)
                    begin
                        res_valid   = 1'b1;
                        res_kind    = KIND_DISCARD;
                        remain_next = '0;
                    end
                    else if (remain_reg == '0)
                    begin
                        res_valid = 1'b1;
                        res_kind  = KIND_EMPTY;
                        res_last  = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_BODY;
                    end
                end
                else if (b == CH_LF && prev_cr)
                begin
                    // end of line: commit a parsed length, or flag a length with no digits
                    if (stage_reg == NS_LEAD || stage_reg == NS_SIGN)
                    begin
                        bad_next = 1'b1;
                    end
                    else if (stage_reg == NS_DIGITS || stage_reg == NS_ENDED)
                    begin
                        found_next  = 1'b1;
                        remain_next = acc_reg;
                        covf_next   = lovf_reg;
                    end
                    prefix_next   = '0;
                    mismatch_next = 1'b0;
                    stage_next    = NS_IDLE;
                    acc_next      = '0;
                    lovf_next     = 1'b0;
                end
                else
                begin
                    case (stage_reg)
                        NS_IDLE:
                        begin
                            if (!mismatch_reg && (prefix_reg < PREFIX_W'(PREFIX_LEN)))
                            begin
                                if (low_b == key_char(prefix_reg))
                                begin
                                    prefix_next = prefix_reg + PREFIX_W'(1);
                                    if (prefix_reg == PREFIX_W'(PREFIX_LEN - 1))
                                    begin
                                        stage_next = NS_LEAD;
                                    end
                                end
                                else
                                begin
                                    mismatch_next = 1'b1;
                                end
                            end
                        end
                        NS_LEAD, NS_SIGN:
                        begin
                            if (is_digit)
                            begin
                                lovf_next  = mul_ovf;
                                acc_next   = mul_ovf ? '1 : acc_mul[LW-1:0];
                                stage_next = NS_DIGITS;
                            end
                            else if (stage_reg == NS_LEAD && b == CH_PLUS)
                            begin
                                stage_next = NS_SIGN;
                            end
                            else if (stage_reg == NS_SIGN || !is_space)
                            begin
                                bad_next      = 1'b1;
                                stage_next    = NS_IDLE;
                                mismatch_next = 1'b1;
                            end
                        end
                        NS_DIGITS:
                        begin
                            if (is_digit)
                            begin
                                lovf_next = mul_ovf;
                                acc_next  = mul_ovf ? '1 : acc_mul[LW-1:0];
                            end
                            else
                            begin
                                stage_next = NS_ENDED;
                            end
                        end
                        default:
                        begin
                            stage_next = stage_reg;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            term_reg      <= TM_NONE;
            prefix_reg    <= '0;
            mismatch_reg  <= 1'b0;
            stage_reg     <= NS_IDLE;
            acc_reg       <= '0;
            found_reg     <= 1'b0;
            bad_reg       <= 1'b0;
            remain_reg    <= '0;
            lovf_reg      <= 1'b0;
            covf_reg      <= 1'b0;
            max_len_reg   <= 32'd1048576;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            term_reg     <= term_next;
            prefix_reg   <= prefix_next;
            mismatch_reg <= mismatch_next;
            stage_reg    <= stage_next;
            acc_reg      <= acc_next;
            found_reg    <= found_next;
            bad_reg      <= bad_next;
            remain_reg   <= remain_next;
            lovf_reg     <= lovf_next;
            covf_reg     <= covf_next;
            if (cfg_we)
            begin
                max_len_reg <= cfg_data;
            end
            if (in_ready)
            begin
                out_valid_reg <= in_fire && res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && res_valid)
        begin
            out_kind_reg <= res_kind;
            out_byte_reg <= res_byte;
            out_last_reg <= res_last;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.kind            = out_kind_reg;
    assign out_ch.body_byte       = out_byte_reg;
    assign out_ch.last_of_message = out_last_reg;

`ifndef SYNTHESIS
    a_body_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_BODY |-> remain_reg != '0)
        else $error("body phase with no bytes remaining");

    a_body_gives_byte: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && phase_reg == PH_BODY |=> out_valid_reg && out_kind_reg == KIND_BODY)
        else $error("body byte not registered as a body request");

    a_last_ends_body: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && phase_reg == PH_BODY && remain_reg == LW'(1) |=> phase_reg == PH_HEADER)
        else $error("body phase kept after final byte");

    a_discard_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_kind_reg == KIND_DISCARD |-> !out_last_reg)
        else $error("discarded header marked as last");

    a_prefix_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        stage_reg != NS_IDLE && !mismatch_reg |-> prefix_reg == PREFIX_W'(PREFIX_LEN))
        else $error("number parse without full key");
`endif

endmodule

[dv/tb_content_length_deframer.sv]
`timescale 1ns / 1ps
// Self-checking bench for content_length_deframer: byte stream in, body bytes and events out.
// Depends on cld_pkg, cld_in_if, cld_out_if and the deframer RTL.
module tb_content_length_deframer;
    import cld_pkg::*;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] body_byte;
        logic       last_mark;
    } frame_result_t;

    // Tracks header parsing and body counting, and holds the expected results in order.
    class cld_scoreboard;
        logic [31:0]   max_len;
        phase_t        phase;
        term_t         term;
        logic [4:0]    key_pos;
        logic          mismatch;
        stage_t        stage;
        logic [31:0]   acc;
        logic          acc_ovf;
        logic          found;
        logic          bad;
        logic [31:0]   remaining;
        logic          held_ovf;
        frame_result_t expected_q[$];
        int            errors;
        int            bytes_in;
        string         key_text;

        function new();
            key_text  = "content-length:";
            max_len   = 32'd1048576;
            phase     = PH_HEADER;
            remaining = '0;
            errors    = 0;
            bytes_in  = 0;
            clear_header();
        endfunction

        function void clear_line();
            key_pos  = '0;
            mismatch = 1'b0;
            stage    = NS_IDLE;
            acc      = '0;
            acc_ovf  = 1'b0;
        endfunction

        function void clear_header();
            clear_line();
            term     = TM_NONE;
            found    = 1'b0;
            bad      = 1'b0;
            held_ovf = 1'b0;
        endfunction

        function void mark_bad();
            bad      = 1'b1;
            stage    = NS_IDLE;
            mismatch = 1'b1;
        endfunction

        function void add_digit(logic [7:0] b);
            logic [63:0] d;
            logic [63:0] cap;
            d   = {56'd0, b - CH_ZERO};
            cap = (64'hFFFF_FFFF - d) / 64'd10;
            if (acc_ovf || {32'd0, acc} > cap)
            begin
                acc_ovf = 1'b1;
                acc     = '1;
            end
            else
            begin
                acc = acc * 32'd10 + d[31:0];
            end
        endfunction

        function void line_byte(logic [7:0] b);
            logic       digit;
            logic       blank;
            logic [7:0] low;
            digit = b >= CH_ZERO && b <= CH_NINE;
            blank = b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
            low   = (b >= CH_UP_A && b <= CH_UP_Z) ? b + 8'd32 : b;
            case (stage)
                NS_IDLE:
                begin
                    if (!mismatch && key_pos < PREFIX_LEN)
                    begin
                        if (low == key_text[key_pos])
                        begin
                            key_pos++;
                            if (key_pos == PREFIX_LEN)
                                stage = NS_LEAD;
                        end
                        else
                        begin
                            mismatch = 1'b1;
                        end
                    end
                end
                NS_LEAD:
                begin
                    if (digit)
                    begin
                        add_digit(b);
                        stage = NS_DIGITS;
                    end
                    else if (b == CH_PLUS)
                        stage = NS_SIGN;
                    else if (!blank)
                        mark_bad();
                end
                NS_SIGN:
                begin
                    if (digit)
                    begin
                        add_digit(b);
                        stage = NS_DIGITS;
                    end
                    else
                        mark_bad();
                end
                NS_DIGITS:
                begin
                    if (digit)
                        add_digit(b);
                    else
                        stage = NS_ENDED;
                end
                default: ;
            endcase
        endfunction

        function void end_line();
            if (stage == NS_LEAD || stage == NS_SIGN)
                bad = 1'b1;
            else if (stage == NS_DIGITS || stage == NS_ENDED)
            begin
                found     = 1'b1;
                remaining = acc;
                held_ovf  = acc_ovf;
            end
            clear_line();
        endfunction

        function void note_byte(logic [7:0] b);
            frame_result_t r;
            logic          prev_cr;
            logic          done;
            logic          too_big;
            bytes_in++;
            r.kind      = KIND_BODY;
            r.body_byte = 8'h00;
            r.last_mark = 1'b0;
            if (phase == PH_BODY)
            begin
                r.body_byte = b;
                r.last_mark = remaining == 32'd1;
                if (remaining != 0)
                    remaining--;
                if (remaining == 0)
                    phase = PH_HEADER;
                expected_q.push_back(r);
                return;
            end
            prev_cr = term == TM_CR || term == TM_CRLFCR;
            done    = 1'b0;
            if (b == CH_CR)
                term = (term == TM_CRLF) ? TM_CRLFCR : TM_CR;
            else if (b == CH_LF)
            begin
                done = term == TM_CRLFCR;
                term = (term == TM_CR) ? TM_CRLF : TM_NONE;
            end
            else
                term = TM_NONE;
            if (done)
            begin
                too_big = held_ovf || remaining > max_len;
                if (bad || !found || too_big)
                begin
                    r.kind    = KIND_DISCARD;
                    remaining = '0;
                    clear_header();
                    expected_q.push_back(r);
                    return;
                end
                clear_header();
                if (remaining == 0)
                begin
                    r.kind      = KIND_EMPTY;
                    r.last_mark = 1'b1;
                    expected_q.push_back(r);
                end
                else
                    phase = PH_BODY;
                return;
            end
            if (b == CH_LF && prev_cr)
                end_line();
            else
                line_byte(b);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function int unsigned body_left();
            return (phase == PH_BODY) ? remaining : 0;
        endfunction

        function void check(kind_t kind, logic [7:0] body_byte, logic last_mark);
            frame_result_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: kind %0d byte %02h last %0d",
                         $time, kind, body_byte, last_mark);
                return;
            end
            want = expected_q.pop_front();
            if (want.kind !== kind || want.body_byte !== body_byte ||
                want.last_mark !== last_mark)
            begin
                errors++;
                $display("%0t: expected kind %0d byte %02h last %0d, %s",
                         $time, want.kind, want.body_byte, want.last_mark,
                         $sformatf("got kind %0d byte %02h last %0d",
                                   kind, body_byte, last_mark));
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_data;
    bit          calm;
    cld_scoreboard sb;

    cld_in_if  in_ch();
    cld_out_if out_ch();

    content_length_deframer #(
        .LENGTH_WIDTH(32)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_ch.ready <= calm || $urandom_range(99) >= 30;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check(out_ch.kind, out_ch.body_byte, out_ch.last_of_message);
    end

    task automatic send_byte(input logic [7:0] b);
        while (!calm && $urandom_range(99) < 30)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sb.note_byte(b);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_line(input string s);
        send_text(s);
        send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    task automatic send_body();
        int unsigned n;
        n = sb.body_left();
        repeat (n)
            send_byte(8'($urandom_range(255)));
    endtask

    // Drain pending requests before touching the limit.
    task automatic write_limit(input logic [31:0] value);
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        sb.max_len = value;
    endtask

    function automatic string junk_text(input int n);
        string      s;
        int unsigned pick;
        s = "";
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                s = $sformatf("%s%c", s, CH_CR);
            else if (pick < 16)
                s = $sformatf("%s%c", s, CH_LF);
            else
                s = $sformatf("%s%c", s, 8'($urandom_range(8'h21, 8'h7E)));
        end
        return s;
    endfunction

    task automatic send_length_line();
        string       s;
        int unsigned pick;
        logic [7:0]  c;
        logic [31:0] v;
        s = "";
        for (int i = 0; i < PREFIX_LEN; i++)
        begin
            c = sb.key_text[i];
            if (c >= 8'h61 && c <= 8'h7A && $urandom_range(1))
                c = c - 8'd32;
            s = $sformatf("%s%c", s, c);
        end
        // corrupt the key now and then
        if ($urandom_range(99) < 10)
            s[$urandom_range(PREFIX_LEN - 1)] = "#";
        repeat ($urandom_range(0, 3))
        begin
            case ($urandom_range(4))
                0:       c = CH_TAB;
                1:       c = 8'h0B;
                2:       c = 8'h0C;
                3:       c = CH_LF;
                default: c = CH_SPACE;
            endcase
            s = $sformatf("%s%c", s, c);
        end
        pick = $urandom_range(99);
        if (pick < 15)
            s = {s, "+"};
        else if (pick < 20)
            s = {s, "-"};
        else if (pick < 23)
            s = {s, "++"};
        pick = $urandom_range(99);
        if (pick < 55)
            s = $sformatf("%s%0d", s, $urandom_range(0, 9));
        else if (pick < 70)
            s = $sformatf("%s%0d", s, $urandom_range(10, 60));
        else if (pick < 78)
            s = $sformatf("%s000%0d", s, $urandom_range(0, 20));
        else if (pick >= 88)
        begin
            v = $urandom;
            if (v <= sb.max_len)
                s = {s, $urandom_range(1) ? "4294967296" : "99999999999"};
            else
                s = $sformatf("%s%0d", s, v);
        end
        if ($urandom_range(99) < 20)
            s = {s, " ", junk_text($urandom_range(1, 4))};
        send_line(s);
    endtask

    task automatic send_random_frame();
        int unsigned pick;
        int unsigned extra;
        int unsigned at;
        logic [7:0]  b;
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            repeat ($urandom_range(1, 12))
            begin
                if ($urandom_range(3) == 0)
                    b = $urandom_range(1) ? CH_CR : CH_LF;
                else
                    b = 8'($urandom_range(255));
                send_byte(b);
            end
            return;
        end
        extra = $urandom_range(0, 3);
        at    = $urandom_range(0, extra);
        for (int i = 0; i <= extra; i++)
        begin
            if (i == at && pick >= 14)
                send_length_line();
            else
                send_line(junk_text($urandom_range(1, 8)));
            if (i == at && pick >= 85)
                send_length_line();
        end
        send_line("");
        send_body();
    endtask

    initial
    begin
        int directed_end;
        int waited;
        sb            = new();
        rst_n         = 1'b0;
        calm          = 1'b0;
        cfg_we        <= 1'b0;
        cfg_data      <= '0;
        in_ch.valid   <= 1'b0;
        in_ch.in_byte <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_line("Content-Length: 3");
        send_line("");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h5A);
        send_line("CONTENT-LENGTH:\t+0");
        send_line("");
        send_line("Host: x");
        send_line("");
        send_line("content-length: \v\f");
        send_line("");
        send_line("content-length:+");
        send_line("");
        send_line("content-length: -4");
        send_line("");
        send_line("content-length: 99999999999");
        send_line("");
        send_line("content-length: 2000000");
        send_line("content-Length: 1;");
        send_line("");
        send_body();
        send_text("x-a");
        send_byte(CH_CR);
        send_line("b");
        send_text("content-length:");
        send_byte(CH_LF);
        send_byte(CH_CR);
        send_line("2");
        send_line("");
        send_body();
        // change the limit with a header half received
        send_line("content-length: 4");
        write_limit(32'd3);
        send_line("");
        write_limit(32'd0);
        send_line("content-length: 0");
        send_line("");
        send_line("content-length: 1");
        send_line("");
        directed_end = sb.bytes_in;

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:       write_limit(32'hFFFF_FFFF);
                1:       write_limit($urandom_range(1, 40));
                2:       write_limit(32'd0);
                default: write_limit($urandom);
            endcase
            while (sb.bytes_in < directed_end + (p + 1) * 400)
            begin
                calm = sb.bytes_in >= 900 && sb.bytes_in < 1250;
                send_random_frame();
            end
        end
        calm = 1'b0;

        in_ch.valid <= 1'b0;
        @(posedge clk);
        waited = 0;
        while (sb.pending() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
        if (sb.pending() != 0)
        begin
            sb.errors++;
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
        end
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

[content_length_deframer.f]
hw/rtl/cld_pkg.sv
hw/rtl/cld_in_if.sv
hw/rtl/cld_out_if.sv
hw/rtl/content_length_deframer.sv
dv/tb_content_length_deframer.sv
